@@ sv/calendar_epoch_converter_assert.svh @@
// Assertion macros for the calendar epoch converter checks.
`ifndef CALENDAR_EPOCH_CONVERTER_ASSERT_SVH
`define CALENDAR_EPOCH_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar epoch converter check failed");

// next-cycle implication, sampled on clk, off during rst
`define CEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar epoch converter check failed");

`endif

@@ sv/cec_pkg.sv @@
// Shared types, constants and calendar tables of the calendar epoch converter.
package cec_pkg;

  localparam logic [11:0] BASE_YEAR       = 12'd2000;
  localparam logic [31:0] DAYS_TO_BASE    = 32'd10957;
  localparam logic [31:0] SECS_TO_BASE    = 32'd946684800;
  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN    = 17'd60;
  localparam logic [3:0]  MONTHS          = 4'd12;
  localparam logic [6:0]  CENTURY_LAST    = 7'd99;
  localparam logic [8:0]  QUAD_CENT_LAST  = 9'd399;
  localparam logic [12:0] DIV25_RECIP     = 13'd5243;
  localparam int          DIV25_SHIFT     = 17;
  localparam int          DAY_LOW_BITS    = 7;
  localparam logic [9:0]  DAY_DIV_HI      = 10'd675;
  localparam logic [25:0] DAY_RECIP       = 26'd50903317;
  localparam int          DAY_RECIP_SHIFT = 35;
  localparam logic [17:0] MIN_RECIP       = 18'd139811;
  localparam int          MIN_RECIP_SHIFT = 23;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_QUOT,
    ST_DIV_TAKE,
    ST_YEAR,
    ST_MONTH,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_MIN,
    DIV_HOUR
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_quot;
    logic     div_take;
    div_sel_t div_sel;
    logic     year_step;
    logic     mon_step;
    logic     mul;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic to_date;
    logic year_more;
    logic mon_more;
  } status_t;

  function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
    logic [4:0] d;
    case (idx)
      4'd1: begin
        d = leap ? 5'd29 : 5'd28;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        d = 5'd30;
      end
      default: begin
        d = 5'd31;
      end
    endcase
    return d;
  endfunction

  function automatic logic [8:0] year_days(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

@@ sv/calendar_epoch_converter.sv @@
// Top level of the calendar epoch converter.
// Date to epoch: after the word is taken, the walk of years from 2000, the walk of months and
// the multiply run in turn. Epoch to date: three reciprocal divisions (day, minute, hour),
// each a quotient step and a take step, then the walk of years and the walk of months.
// One word is in work at a time; a new word is taken while the last result waits.
// rst (synchronous) returns the controller to idle and drops out_valid.
module calendar_epoch_converter import cec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] epoch_in,
  input  logic [11:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] epoch_out,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);

  cmd_t    cmd;
  status_t status;

  cec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cec_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .req_type   (req_type),
    .epoch_in   (epoch_in),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .hour_in    (hour_in),
    .minute_in  (minute_in),
    .second_in  (second_in),
    .epoch_out  (epoch_out),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .hour_out   (hour_out),
    .minute_out (minute_out),
    .second_out (second_out)
  );

endmodule

@@ sv/cec_datapath.sv @@
// Datapath of the calendar epoch converter: divider, year and month walk, epoch sum.
module cec_datapath import cec_pkg::*; (
  input  logic        clk,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        req_type,
  input  logic [31:0] epoch_in,
  input  logic [11:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  output logic [31:0] epoch_out,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);

  logic        to_date;
  logic [11:0] year_r;
  logic [3:0]  mon_c;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [7:0]  q25;
  logic [11:0] y;
  logic [6:0]  c100;
  logic [8:0]  c400;
  logic [3:0]  mi;
  logic [31:0] days;
  logic [31:0] acc;
  logic [16:0] dq;
  logic [16:0] dr;

  logic [24:0] q25_prod;
  logic [11:0] q25x;
  logic        div25;
  logic        leap_in;
  logic        leap_cur;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [50:0] qday_prod;
  logic [34:0] q60_prod;
  logic [25:0] day_back;
  logic [24:0] day_rem;
  logic [16:0] back60;
  logic [16:0] rem60;
  logic [31:0] days_f;
  logic [31:0] prod;
  logic [16:0] tod;

  assign q25_prod = 25'(year_in) * 25'(DIV25_RECIP);
  assign q25x     = 12'({q25, 4'b0}) + 12'({q25, 3'b0}) + 12'(q25);
  assign div25    = (q25x == year_r);
  assign leap_in  = (year_r[1:0] == 2'd0) && (!div25 || (year_r[3:0] == 4'd0));
  assign leap_cur = (y[1:0] == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
  assign ylen     = year_days(leap_cur);
  assign mlen     = month_days(mi, to_date ? leap_cur : leap_in);

  assign qday_prod = 51'(acc[31:DAY_LOW_BITS]) * 51'(DAY_RECIP);
  assign q60_prod  = 35'(dr) * 35'(MIN_RECIP);
  assign day_back  = 26'(dq[15:0]) * 26'(DAY_DIV_HI);
  assign day_rem   = acc[31:DAY_LOW_BITS] - day_back[24:0];
  assign back60    = dq * SECS_PER_MIN;
  assign rem60     = dr - back60;

  assign days_f = days + 32'(day_r) - 32'd1;
  assign prod   = (days_f + DAYS_TO_BASE) * 32'(SECS_PER_DAY);
  assign tod    = 17'(hour_r) * SECS_PER_HOUR + 17'(min_r) * SECS_PER_MIN + 17'(sec_r);

  always_comb begin
    status.to_date = to_date;
    if (to_date) begin
      status.year_more = (days >= 32'(ylen));
      status.mon_more  = (mi < MONTHS) && (days >= 32'(mlen));
    end else begin
      status.year_more = (y < year_r);
      status.mon_more  = ((mi + 4'd1) < mon_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      to_date <= req_type;
      acc     <= epoch_in - SECS_TO_BASE;
      year_r  <= year_in;
      mon_c   <= (month_in > MONTHS) ? MONTHS : month_in;
      day_r   <= day_in;
      hour_r  <= hour_in;
      min_r   <= minute_in;
      sec_r   <= second_in;
      q25     <= q25_prod[DIV25_SHIFT +: 8];
      y       <= BASE_YEAR;
      c100    <= 7'd0;
      c400    <= 9'd0;
      mi      <= 4'd0;
      days    <= 32'd0;
    end
    if (cmd.div_quot) begin
      case (cmd.div_sel)
        DIV_DAY: begin
          dq <= 17'(qday_prod[DAY_RECIP_SHIFT +: 16]);
        end
        default: begin
          dq <= 17'(q60_prod[MIN_RECIP_SHIFT +: 12]);
        end
      endcase
    end
    if (cmd.div_take) begin
      case (cmd.div_sel)
        DIV_MIN: begin
          sec_r <= rem60[5:0];
          dr    <= dq;
        end
        DIV_HOUR: begin
          hour_r <= dq[4:0];
          min_r  <= rem60[5:0];
        end
        default: begin
          days <= 32'(dq);
          dr   <= {day_rem[9:0], acc[DAY_LOW_BITS-1:0]};
        end
      endcase
    end
    if (cmd.year_step) begin
      days <= to_date ? days - 32'(ylen) : days + 32'(ylen);
      y    <= y + 12'd1;
      c100 <= (c100 == CENTURY_LAST) ? 7'd0 : c100 + 7'd1;
      c400 <= (c400 == QUAD_CENT_LAST) ? 9'd0 : c400 + 9'd1;
    end
    if (cmd.mon_step) begin
      days <= to_date ? days - 32'(mlen) : days + 32'(mlen);
      mi   <= mi + 4'd1;
    end
    if (cmd.mul) begin
      acc <= prod;
    end
    if (cmd.finish) begin
      if (to_date) begin
        epoch_out  <= 32'd0;
        year_out   <= y;
        month_out  <= mi + 4'd1;
        day_out    <= days[4:0] + 5'd1;
        hour_out   <= hour_r;
        minute_out <= min_r;
        second_out <= sec_r;
      end else begin
        epoch_out  <= acc + 32'(tod);
        year_out   <= 12'd0;
        month_out  <= 4'd0;
        day_out    <= 5'd0;
        hour_out   <= 5'd0;
        minute_out <= 6'd0;
        second_out <= 6'd0;
      end
    end
  end

endmodule

@@ sv/cec_ctrl.sv @@
// Controller state machine of the calendar epoch converter.
module cec_ctrl import cec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t   state, state_next;
  div_sel_t sel, sel_next;
  logic     out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= DIV_DAY;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.div_sel = sel;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        sel_next   = DIV_DAY;
        state_next = status.to_date ? ST_DIV_QUOT : ST_YEAR;
      end
      ST_DIV_QUOT: begin
        cmd.div_quot = 1'b1;
        state_next   = ST_DIV_TAKE;
      end
      ST_DIV_TAKE: begin
        cmd.div_take = 1'b1;
        case (sel)
          DIV_DAY: begin
            sel_next   = DIV_MIN;
            state_next = ST_DIV_QUOT;
          end
          DIV_MIN: begin
            sel_next   = DIV_HOUR;
            state_next = ST_DIV_QUOT;
          end
          default: begin
            state_next = ST_YEAR;
          end
        endcase
      end
      ST_YEAR: begin
        if (status.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status.mon_more) begin
          cmd.mon_step = 1'b1;
        end else begin
          state_next = status.to_date ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && !out_ready;
    end
  end

endmodule

@@ sv/cec_checker.sv @@
// Port-level checks of the calendar epoch converter, bound to the top level.
`include "calendar_epoch_converter_assert.svh"

module cec_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] epoch_out,
  input logic [11:0] year_out,
  input logic [3:0]  month_out,
  input logic [4:0]  day_out,
  input logic [4:0]  hour_out,
  input logic [5:0]  minute_out,
  input logic [5:0]  second_out
);

  `CEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(epoch_out) && $stable(year_out))
  `CEC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `CEC_ASSERT_NOW(a_date_word, out_valid && (year_out != 12'd0), (epoch_out == 32'd0) && (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out != 5'd0) && (hour_out <= 5'd23) && (minute_out <= 6'd59) && (second_out <= 6'd59))
  `CEC_ASSERT_NOW(a_epoch_word, out_valid && (year_out == 12'd0), (month_out == 4'd0) && (day_out == 5'd0) && (hour_out == 5'd0) && (minute_out == 6'd0) && (second_out == 6'd0))

endmodule

bind calendar_epoch_converter cec_checker u_cec_checker (.*);
